// ----- rtl/core/dpsc_pkg.sv -----
// Shared types, codes and constants for the dual-channel staged-commit PWM.
// Holds the request codes, field widths and the divide-by-65535 helper.
// No dependencies.
package dpsc_pkg;

	// Field widths
	localparam int unsigned PERIOD_W = 24;
	localparam int unsigned DUTY_W   = 16;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned REQ_W    = 2;

	// Product of duty and period plus the rounding bias
	localparam int unsigned PROD_W   = DUTY_W + PERIOD_W;
	// Quotient width: a compare never exceeds the period
	localparam int unsigned QUOT_W   = PERIOD_W;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(500000);
	localparam int unsigned COUNTER_WIDTH_DEF = 24;

	localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(32767);
	localparam logic [16:0]       DUTY_FULL  = 17'(65535);

	// Request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_TICK     = 2'd0,
		REQ_STAGE    = 2'd1,
		REQ_TAKE     = 2'd2,
		REQ_FORCEOFF = 2'd3
	} req_t;

	// One result item
	typedef struct packed {
		logic              pwm_one_level;
		logic              pwm_two_level;
		logic              commit_taken;
		logic [TIME_W-1:0] commit_time_us;
		logic              stage_pending;
	} result_t;

	// floor(x / 65535) for x below 65535 * 2^24, no divider:
	// x = 65535*a + (a+b), then the same fold once more on the small sum.
	function automatic logic [QUOT_W-1:0] div_full(input logic [PROD_W-1:0] x);
		logic [QUOT_W-1:0] a;
		logic [15:0]       b;
		logic [QUOT_W:0]   s;
		logic [8:0]        c;
		logic [15:0]       d;
		logic [16:0]       e;
		a = x[PROD_W-1:16];
		b = x[15:0];
		s = {1'b0, a} + {9'b0, b};
		c = s[QUOT_W:16];
		d = s[15:0];
		e = {8'b0, c} + {1'b0, d};
		return a + QUOT_W'(c) + QUOT_W'(e >= DUTY_FULL);
	endfunction

endpackage

// ----- rtl/core/dual_pwm_staged_commit.sv -----
// Top level of the two-channel edge-aligned PWM with preload and commit handshake.
// Input register, combinational state update, three-entry result queue.
// Depends on dpsc_pkg.
//
//  channel | signals                                         | role
//  --------+-------------------------------------------------+-------------------------
//  in      | in_valid, in_ready, req_type, duty_one,         | request items
//          | duty_two, now_us                                |
//  out     | out_valid, out_ready, pwm_one_level,            | one result per item
//          | pwm_two_level, commit_taken, commit_time_us,    |
//          | stage_pending                                   |
//  cfg     | cfg_valid, cfg_ready, cfg_data                  | period_ticks write
//
// One item per cycle sustained while the output takes results; an accepted item
// passes the input register, is then written to the queue and can leave it. The
// state update is combinational logic on the registered item: the duty multiply
// for stage items and the divide-by-65535 fold on period wraps set that path.
// in_ready comes from registers only: it stays high while the queue and the
// input register together hold fewer than three items, so at most three items
// sit in the block before a stalled output stops the input. Reset clears the
// control and timer state; no clearing pass.
module dual_pwm_staged_commit #(
	parameter int unsigned COUNTER_WIDTH = dpsc_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [dpsc_pkg::REQ_W-1:0]     req_type,
	input  logic [dpsc_pkg::DUTY_W-1:0]    duty_one,
	input  logic [dpsc_pkg::DUTY_W-1:0]    duty_two,
	input  logic [dpsc_pkg::TIME_W-1:0]    now_us,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           pwm_one_level,
	output logic                           pwm_two_level,
	output logic                           commit_taken,
	output logic [dpsc_pkg::TIME_W-1:0]    commit_time_us,
	output logic                           stage_pending,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dpsc_pkg::PERIOD_W-1:0]  cfg_data
);

	localparam int unsigned W  = COUNTER_WIDTH;
	localparam int unsigned QW = dpsc_pkg::QUOT_W;
	localparam int unsigned MW = (W > QW) ? W : QW;
	localparam int unsigned LW = ((W + 1) > dpsc_pkg::PERIOD_W) ? (W + 1) : dpsc_pkg::PERIOD_W;
	localparam int unsigned QDEPTH = 3;
	localparam logic [W-1:0] CNT_MAX = {W{1'b1}};

	// Quotient saturated to the counter width
	function automatic logic [W-1:0] to_compare(input logic [dpsc_pkg::PROD_W-1:0] x);
		logic [MW-1:0] q;
		q = MW'(dpsc_pkg::div_full(x));
		return (q > MW'(CNT_MAX)) ? CNT_MAX : W'(q);
	endfunction

	// Configuration
	logic [dpsc_pkg::PERIOD_W-1:0] period_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= dpsc_pkg::PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			period_q <= cfg_data;
		end
	end

	// Input register
	logic                          valid_s1;
	dpsc_pkg::req_t                req_s1;
	logic [dpsc_pkg::DUTY_W-1:0]   duty_one_s1;
	logic [dpsc_pkg::DUTY_W-1:0]   duty_two_s1;
	logic [dpsc_pkg::TIME_W-1:0]   now_s1;
	logic [1:0]                    qcnt_q;
	logic                          in_acc;

	assign in_ready = ({1'b0, qcnt_q} + {2'b0, valid_s1}) < 3'(QDEPTH);
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1      <= dpsc_pkg::req_t'(req_type);
			duty_one_s1 <= duty_one;
			duty_two_s1 <= duty_two;
			now_s1      <= now_us;
		end
	end

	// Timer state
	logic [W-1:0]                  cnt_q;
	logic [W-1:0]                  act_one_q, act_two_q;
	logic [dpsc_pkg::PROD_W-1:0]   pre_one_q, pre_two_q;
	logic                          pending_q, ready_q;
	logic [dpsc_pkg::TIME_W-1:0]   stamp_q;

	logic [W-1:0]                  cnt_n;
	logic [W-1:0]                  act_one_n, act_two_n;
	logic [dpsc_pkg::PROD_W-1:0]   pre_one_n, pre_two_n;
	logic                          pending_n, ready_n;
	logic [dpsc_pkg::TIME_W-1:0]   stamp_n;
	logic [W:0]                    cnt_inc;
	logic                          wrap;
	dpsc_pkg::result_t             res;

	// Counter wraps at min(period, 2^W)
	assign cnt_inc = {1'b0, cnt_q} + {{W{1'b0}}, 1'b1};
	assign wrap    = cnt_inc[W] || (LW'(cnt_inc) >= LW'(period_q));

	// Next state and result for the registered item
	always_comb begin
		cnt_n     = cnt_q;
		act_one_n = act_one_q;
		act_two_n = act_two_q;
		pre_one_n = pre_one_q;
		pre_two_n = pre_two_q;
		pending_n = pending_q;
		ready_n   = ready_q;
		stamp_n   = stamp_q;
		res.commit_taken   = 1'b0;
		res.commit_time_us = '0;
		case (req_s1)
			dpsc_pkg::REQ_TICK: begin
				if (wrap) begin
					cnt_n     = '0;
					act_one_n = to_compare(pre_one_q);
					act_two_n = to_compare(pre_two_q);
					if (pending_q) begin
						stamp_n   = now_s1;
						pending_n = 1'b0;
						ready_n   = 1'b1;
					end
				end else begin
					cnt_n = cnt_inc[W-1:0];
				end
			end
			dpsc_pkg::REQ_STAGE: begin
				// Stored with the rounding bias; divided on the wrap
				pre_one_n = duty_one_s1 * period_q + dpsc_pkg::ROUND_BIAS;
				pre_two_n = duty_two_s1 * period_q + dpsc_pkg::ROUND_BIAS;
				pending_n = 1'b1;
				ready_n   = 1'b0;
			end
			dpsc_pkg::REQ_TAKE: begin
				if (ready_q) begin
					res.commit_taken   = 1'b1;
					res.commit_time_us = stamp_q;
					ready_n            = 1'b0;
				end
			end
			dpsc_pkg::REQ_FORCEOFF: begin
				cnt_n     = '0;
				act_one_n = '0;
				act_two_n = '0;
				pre_one_n = '0;
				pre_two_n = '0;
				pending_n = 1'b0;
				ready_n   = 1'b0;
			end
			default: begin
			end
		endcase
		res.pwm_one_level = cnt_n < act_one_n;
		res.pwm_two_level = cnt_n < act_two_n;
		res.stage_pending = pending_n;
	end

	// Zero preload product gives a compare of zero, matching a cleared preload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			act_one_q <= '0;
			act_two_q <= '0;
			pre_one_q <= '0;
			pre_two_q <= '0;
			pending_q <= 1'b0;
			ready_q   <= 1'b0;
			stamp_q   <= '0;
		end else if (valid_s1) begin
			cnt_q     <= cnt_n;
			act_one_q <= act_one_n;
			act_two_q <= act_two_n;
			pre_one_q <= pre_one_n;
			pre_two_q <= pre_two_n;
			pending_q <= pending_n;
			ready_q   <= ready_n;
			stamp_q   <= stamp_n;
		end
	end

	// Result queue
	dpsc_pkg::result_t res_q [QDEPTH];
	logic [1:0]        wptr_q, rptr_q;
	logic              pop;

	assign out_valid = (qcnt_q != 2'd0);
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			qcnt_q <= '0;
		end else begin
			if (valid_s1) begin
				wptr_q <= (wptr_q == 2'(QDEPTH - 1)) ? 2'd0 : wptr_q + 2'd1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == 2'(QDEPTH - 1)) ? 2'd0 : rptr_q + 2'd1;
			end
			qcnt_q <= qcnt_q + {1'b0, valid_s1} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_q[wptr_q] <= res;
		end
	end

	assign pwm_one_level  = res_q[rptr_q].pwm_one_level;
	assign pwm_two_level  = res_q[rptr_q].pwm_two_level;
	assign commit_taken   = res_q[rptr_q].commit_taken;
	assign commit_time_us = res_q[rptr_q].commit_time_us;
	assign stage_pending  = res_q[rptr_q].stage_pending;

endmodule
